### hdl/dhtbl_pkg.sv
// Shared types and constants for the deduplicating handle table.
package dhtbl_pkg;

    localparam int TABLE_SLOTS = 512;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int IDX_W       = SLOT_W + 1;
    localparam int CNT_W       = 10;

    localparam logic [31:0]      BASE_RESET = 32'h7700_0000;
    localparam logic [CNT_W-1:0] COUNT_MAX  = {CNT_W{1'b1}};

    typedef logic [SLOT_W-1:0] slot_idx_t;

    // One table entry, used flag included.
    typedef struct packed {
        logic        used;
        logic [15:0] owner;
        logic [31:0] mod_addr;
        logic [31:0] data_addr;
        logic [31:0] data_size;
        logic [15:0] lang;
    } entry_t;

    typedef enum logic [1:0] {
        REQ_ACQUIRE = 2'd0,
        REQ_LOOKUP  = 2'd1,
        REQ_RELEASE = 2'd2,
        REQ_UNKNOWN = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_NEW       = 3'd0,
        ST_REUSED    = 3'd1,
        ST_FULL      = 3'd2,
        ST_LOOKUP_OK = 3'd3,
        ST_INVALID   = 3'd4,
        ST_RELEASED  = 3'd5
    } status_t;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_LOOKUP = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

endpackage

### hdl/dedup_handle_table_unit.sv
// Deduplicating handle table: slot memory, scan sequencer and result register.
//
//  channel | signals                                        | dir | handshake
//  --------+------------------------------------------------+-----+----------------
//  in      | req_type owner_id module_addr data_addr        | in  | in_valid/in_ready
//          | data_size language handle                      |     |
//  out     | status handle_out found_data found_size        | out | out_valid/out_ready
//          | released_count                                 |     |
//  cfg     | cfg_wr_en cfg_wr_data (handle_base)            | in  | write enable only
//
// Acquire and release walk all TABLE_SLOTS entries through the single read
// port of the slot memory, one entry per cycle. An acquire that hits stops
// early. After reset the block sweeps the memory to clear all used flags,
// with in_ready low. The result sits in an output register, so a new item is
// taken while the previous result waits; a stalled output only holds the
// block once the next result is ready.
module dedup_handle_table_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [15:0] owner_id,
    input  logic [31:0] module_addr,
    input  logic [31:0] data_addr,
    input  logic [31:0] data_size,
    input  logic [15:0] language,
    input  logic [31:0] handle,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] handle_out,
    output logic [31:0] found_data,
    output logic [31:0] found_size,
    output logic [9:0]  released_count
);
    import dhtbl_pkg::*;

    localparam slot_idx_t       SLOT_LAST = slot_idx_t'(TABLE_SLOTS - 1);
    localparam logic [IDX_W-1:0] IDX_END  = IDX_W'(TABLE_SLOTS);

    // Slot memory: one write port, one registered read port.
    entry_t    slot_mem [TABLE_SLOTS];
    entry_t    rd_data_reg;
    logic      mem_we;
    slot_idx_t mem_waddr;
    entry_t    mem_wdata;
    slot_idx_t mem_raddr;

    // Control state
    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;        // clear sweep / scan issue index
    logic             rd_vld_reg, rd_vld_next;  // read data in flight for rd_slot
    logic             free_vld_reg, free_vld_next;
    logic             out_valid_reg, out_valid_next;
    logic [31:0]      base_reg;

    // Item payload
    req_t             req_reg, req_next;
    entry_t           key_reg, key_next;        // used bit set, ready to write
    slot_idx_t        rd_slot_reg, rd_slot_next;
    slot_idx_t        hole_slot_reg, hole_slot_next;
    status_t          res_status_reg, res_status_next;
    logic [31:0]      res_handle_reg, res_handle_next;
    logic [31:0]      res_data_reg, res_data_next;
    logic [31:0]      res_size_reg, res_size_next;
    logic [CNT_W-1:0] res_count_reg, res_count_next;

    status_t          out_status_reg;
    logic [31:0]      out_handle_reg, out_data_reg, out_size_reg;
    logic [CNT_W-1:0] out_count_reg;
    logic             load_out;

    // Lookup window, wraps modulo 2^32 like the handles do
    logic [31:0] lk_off;
    logic        lk_in_win;

    // Scan compare on the entry just read
    logic      key_hit, owner_hit, slot_last, free_found;
    slot_idx_t free_pick;

    assign lk_off    = handle - base_reg;
    assign lk_in_win = (lk_off < 32'(TABLE_SLOTS));

    assign owner_hit = rd_data_reg.used && (rd_data_reg.owner == key_reg.owner);
    assign key_hit   = owner_hit
                    && (rd_data_reg.mod_addr  == key_reg.mod_addr)
                    && (rd_data_reg.data_addr == key_reg.data_addr)
                    && (rd_data_reg.data_size == key_reg.data_size)
                    && (rd_data_reg.lang      == key_reg.lang);
    assign slot_last  = (rd_slot_reg == SLOT_LAST);
    assign free_found = free_vld_reg || !rd_data_reg.used;
    assign free_pick  = free_vld_reg ? hole_slot_reg : rd_slot_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= slot_mem[mem_raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        rd_vld_next     = 1'b0;
        rd_slot_next    = rd_slot_reg;
        free_vld_next   = free_vld_reg;
        hole_slot_next  = hole_slot_reg;
        req_next        = req_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_data_next   = res_data_reg;
        res_size_next   = res_size_reg;
        res_count_next  = res_count_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg[SLOT_W-1:0];
        mem_wdata       = '0;
        mem_raddr       = idx_reg[SLOT_W-1:0];
        in_ready        = 1'b0;
        load_out        = 1'b0;
        out_valid_next  = out_valid_reg && !out_ready;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (idx_reg[SLOT_W-1:0] == SLOT_LAST)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    req_next           = req_t'(req_type);
                    key_next.used      = 1'b1;
                    key_next.owner     = owner_id;
                    key_next.mod_addr  = module_addr;
                    key_next.data_addr = data_addr;
                    key_next.data_size = data_size;
                    key_next.lang      = language;
                    idx_next           = '0;
                    free_vld_next      = 1'b0;
                    res_status_next    = ST_INVALID;
                    res_handle_next    = '0;
                    res_data_next      = '0;
                    res_size_next      = '0;
                    res_count_next     = '0;
                    unique case (req_t'(req_type))
                        REQ_ACQUIRE, REQ_RELEASE:
                        begin
                            state_next = S_SCAN;
                        end
                        REQ_LOOKUP:
                        begin
                            // read issued now, data checked in S_LOOKUP
                            mem_raddr = lk_off[SLOT_W-1:0];
                            if (lk_in_win)
                                state_next = S_LOOKUP;
                            else
                                state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // issue side: one read per cycle
                if (idx_reg < IDX_END)
                begin
                    mem_raddr    = idx_reg[SLOT_W-1:0];
                    rd_vld_next  = 1'b1;
                    rd_slot_next = idx_reg[SLOT_W-1:0];
                    idx_next     = idx_reg + 1'b1;
                end
                // check side: entry read last cycle
                if (rd_vld_reg)
                begin
                    if (req_reg == REQ_ACQUIRE)
                    begin
                        if (!free_vld_reg && !rd_data_reg.used)
                        begin
                            free_vld_next  = 1'b1;
                            hole_slot_next = rd_slot_reg;
                        end
                        if (key_hit)
                        begin
                            res_status_next = ST_REUSED;
                            res_handle_next = base_reg + 32'(rd_slot_reg);
                            state_next      = S_DONE;
                        end
                        else if (slot_last)
                        begin
                            if (free_found)
                            begin
                                mem_we          = 1'b1;
                                mem_waddr       = free_pick;
                                mem_wdata       = key_reg;
                                res_status_next = ST_NEW;
                                res_handle_next = base_reg + 32'(free_pick);
                            end
                            else
                            begin
                                res_status_next = ST_FULL;
                            end
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        // release: write-back goes to the slot just read,
                        // never the one being read this cycle
                        if (owner_hit)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = rd_slot_reg;
                            mem_wdata = '0;
                            if (res_count_reg != COUNT_MAX)
                                res_count_next = res_count_reg + 1'b1;
                        end
                        if (slot_last)
                        begin
                            res_status_next = ST_RELEASED;
                            state_next      = S_DONE;
                        end
                    end
                end
            end

            S_LOOKUP:
            begin
                if (rd_data_reg.used)
                begin
                    res_status_next = ST_LOOKUP_OK;
                    res_data_next   = rd_data_reg.data_addr;
                    res_size_next   = rd_data_reg.data_size;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            free_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            base_reg      <= BASE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            rd_vld_reg    <= rd_vld_next;
            free_vld_reg  <= free_vld_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                base_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        key_reg        <= key_next;
        rd_slot_reg    <= rd_slot_next;
        hole_slot_reg  <= hole_slot_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_data_reg   <= res_data_next;
        res_size_reg   <= res_size_next;
        res_count_reg  <= res_count_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_handle_reg <= res_handle_reg;
            out_data_reg   <= res_data_reg;
            out_size_reg   <= res_size_reg;
            out_count_reg  <= res_count_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign handle_out     = out_handle_reg;
    assign found_data     = out_data_reg;
    assign found_size     = out_size_reg;
    assign released_count = out_count_reg;

endmodule

### dv/dedup_handle_table_unit_test.sv
// Self-checking testbench for the deduplicating handle table unit.
`timescale 1ns / 100ps

module dedup_handle_table_unit_test;

    import dhtbl_pkg::*;

    // Cycles with no item moving on either channel before the run is called hung.
    // Worst correct case: the clearing sweep after reset followed by a full
    // acquire or release scan, plus output stalls.
    localparam int WATCHDOG_LIMIT = 6000;
    // Quiet cycles after the last result, to catch stray extra results.
    localparam int TAIL_CYCLES    = 40;
    localparam int RECENT_DEPTH   = 48;

    localparam logic [31:0] BR   = BASE_RESET;
    localparam logic [31:0] Z    = 32'h0000_0000;
    localparam logic [31:0] ONES = 32'hFFFF_FFFF;

    // One request item as seen on the input channel.
    typedef struct {
        req_t        kind;
        logic [15:0] owner;
        logic [31:0] mod_addr;
        logic [31:0] data_addr;
        logic [31:0] data_size;
        logic [15:0] lang;
        logic [31:0] hval;
    } handle_req_t;

    // One result item as seen on the output channel.
    typedef struct {
        status_t     st;
        logic [31:0] hout;
        logic [31:0] fdata;
        logic [31:0] fsize;
        logic [9:0]  cnt;
    } handle_res_t;

    // Directed row: stimulus plus, where obvious, the result typed in by hand.
    typedef struct {
        handle_req_t rq;
        bit          typed;
        handle_res_t res;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type = '0;
    logic [15:0] owner_id = '0;
    logic [31:0] module_addr = '0;
    logic [31:0] data_addr = '0;
    logic [31:0] data_size = '0;
    logic [15:0] language = '0;
    logic [31:0] handle = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [31:0] handle_out;
    logic [31:0] found_data;
    logic [31:0] found_size;
    logic [9:0]  released_count;

    // Idle percentages, set per phase by the sequencer.
    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;

    int n_errors    = 0;
    int n_results   = 0;
    int idle_cycles = 0;

    // Mirror of the slot table and the base register, kept by the predictor.
    logic        mirror_used   [TABLE_SLOTS];
    logic [15:0] mirror_owner  [TABLE_SLOTS];
    logic [31:0] mirror_module [TABLE_SLOTS];
    logic [31:0] mirror_data   [TABLE_SLOTS];
    logic [31:0] mirror_size   [TABLE_SLOTS];
    logic [15:0] mirror_lang   [TABLE_SLOTS];
    logic [31:0] mirror_base;

    handle_res_t pending_results [$];
    handle_req_t recent_keys [$];
    dir_row_t    dir_rows [$];

    handle_res_t no_override = '{ST_INVALID, Z, Z, Z, 10'd0};

    dedup_handle_table_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .owner_id       (owner_id),
        .module_addr    (module_addr),
        .data_addr      (data_addr),
        .data_size      (data_size),
        .language       (language),
        .handle         (handle),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .handle_out     (handle_out),
        .found_data     (found_data),
        .found_size     (found_size),
        .released_count (released_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor: applies one request to the mirror and returns its result.
    // ------------------------------------------------------------------
    function automatic handle_res_t resolve_request(input handle_req_t rq);
        handle_res_t r;
        int          hole_slot;
        int          hit_slot;
        int          cnt;
        logic [31:0] off;
        r         = '{ST_INVALID, Z, Z, Z, 10'd0};
        hole_slot = -1;
        hit_slot  = -1;
        cnt       = 0;
        case (rq.kind)
            REQ_ACQUIRE:
            begin
                // Scan stops at the first matching used slot; free slots seen
                // before it are remembered but only used on a miss.
                for (int i = 0; i < TABLE_SLOTS && hit_slot < 0; i++)
                begin
                    if (!mirror_used[i])
                    begin
                        if (hole_slot < 0)
                            hole_slot = i;
                    end
                    else if (mirror_owner[i] == rq.owner && mirror_module[i] == rq.mod_addr &&
                             mirror_data[i] == rq.data_addr &&
                             mirror_size[i] == rq.data_size && mirror_lang[i] == rq.lang)
                        hit_slot = i;
                end
                if (hit_slot >= 0)
                begin
                    r.st   = ST_REUSED;
                    r.hout = mirror_base + 32'(hit_slot);
                end
                else if (hole_slot >= 0)
                begin
                    mirror_used[hole_slot]   = 1'b1;
                    mirror_owner[hole_slot]  = rq.owner;
                    mirror_module[hole_slot] = rq.mod_addr;
                    mirror_data[hole_slot]   = rq.data_addr;
                    mirror_size[hole_slot]   = rq.data_size;
                    mirror_lang[hole_slot]   = rq.lang;
                    r.st   = ST_NEW;
                    r.hout = mirror_base + 32'(hole_slot);
                end
                else
                    r.st = ST_FULL;
            end
            REQ_LOOKUP:
            begin
                // Offset is taken modulo 2^32, so the window wraps like handles do.
                off = rq.hval - mirror_base;
                if (off < TABLE_SLOTS && mirror_used[off[SLOT_W-1:0]])
                begin
                    r.st    = ST_LOOKUP_OK;
                    r.fdata = mirror_data[off[SLOT_W-1:0]];
                    r.fsize = mirror_size[off[SLOT_W-1:0]];
                end
            end
            REQ_RELEASE:
            begin
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    if (mirror_used[i] && mirror_owner[i] == rq.owner)
                    begin
                        mirror_used[i] = 1'b0;
                        if (cnt < COUNT_MAX)
                            cnt++;
                    end
                end
                r.st  = ST_RELEASED;
                r.cnt = 10'(cnt);
            end
            default: ;  // unknown request: no state change, invalid with zeros
        endcase
        return r;
    endfunction

    // Lowest (or highest) slot that is used (or free); -1 if none.
    function automatic int find_slot(input bit want_used, input bit from_top);
        int found;
        found = -1;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            if (mirror_used[i] == want_used && (from_top || found < 0))
                found = i;
        end
        return found;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    // Small pool of owners so that reuse and release actually find entries.
    function automatic logic [15:0] pick_owner();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'h0001;
            2:       return 16'h00A5;
            3:       return 16'h8000;
            4:       return 16'hFFFF;
            5:       return 16'h7FFE;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic handle_req_t fresh_key(input logic [15:0] owner);
        handle_req_t rq;
        rq.kind      = REQ_ACQUIRE;
        rq.owner     = owner;
        rq.mod_addr  = $urandom;
        rq.data_addr = $urandom;
        rq.data_size = $urandom;
        rq.lang      = 16'($urandom);
        rq.hval      = $urandom;
        return rq;
    endfunction

    function automatic void remember_key(input handle_req_t rq);
        recent_keys.push_back(rq);
        if (recent_keys.size() > RECENT_DEPTH)
            void'(recent_keys.pop_front());
    endfunction

    // Mixed traffic: 40% acquire, 47% lookup, 10% release, 3% unknown type.
    function automatic handle_req_t random_request();
        handle_req_t rq;
        int          sel;
        int          top;
        sel = $urandom_range(99);
        rq  = fresh_key(pick_owner());
        if (sel < 40)
        begin
            sel = $urandom_range(9);
            if (recent_keys.size() != 0 && sel < 6)
            begin
                // exact repeat of an earlier key, or a near miss in one bit
                rq      = recent_keys[$urandom_range(recent_keys.size() - 1)];
                rq.kind = REQ_ACQUIRE;
                if (sel >= 4)
                begin
                    case ($urandom_range(4))
                        0: rq.owner     = rq.owner ^ 16'(1 << $urandom_range(15));
                        1: rq.mod_addr  = rq.mod_addr ^ (32'd1 << $urandom_range(31));
                        2: rq.data_addr = rq.data_addr ^ (32'd1 << $urandom_range(31));
                        3: rq.data_size = rq.data_size ^ (32'd1 << $urandom_range(31));
                        default: rq.lang = rq.lang ^ 16'(1 << $urandom_range(15));
                    endcase
                    remember_key(rq);
                end
            end
            else
                remember_key(rq);
        end
        else if (sel < 87)
        begin
            rq.kind = REQ_LOOKUP;
            top     = find_slot(1'b1, 1'b1) + 4;
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: rq.hval = mirror_base + $urandom_range(top);
                6, 7:             rq.hval = mirror_base + $urandom_range(TABLE_SLOTS - 1);
                8:
                begin
                    // just outside the window on either side
                    if ($urandom_range(1) != 0)
                        rq.hval = mirror_base + TABLE_SLOTS + $urandom_range(3);
                    else
                        rq.hval = mirror_base - 1 - $urandom_range(3);
                end
                default: ;  // keep the fully random handle
            endcase
        end
        else if (sel < 97)
            rq.kind = REQ_RELEASE;
        else
            rq.kind = REQ_UNKNOWN;
        return rq;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    // Offers one item, waits for acceptance, then records what must come back.
    // Valid is only lowered during an idle gap, so back-to-back items keep it high.
    task automatic issue(input handle_req_t rq, input bit typed, input handle_res_t typed_res);
        handle_res_t predicted;
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= rq.kind;
        owner_id    <= rq.owner;
        module_addr <= rq.mod_addr;
        data_addr   <= rq.data_addr;
        data_size   <= rq.data_size;
        language    <= rq.lang;
        handle      <= rq.hval;
        do @(posedge clk); while (!in_ready);
        predicted = resolve_request(rq);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Base register is only written with nothing in flight.
    task automatic set_base(input logic [31:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        mirror_base = value;
    endtask

    // With pressure set, the sender holds off every 40 items until all is back.
    task automatic run_mix(input int n_items, input bit pressure);
        for (int k = 0; k < n_items; k++)
        begin
            issue(random_request(), 1'b0, no_override);
            if (pressure && k % 40 == 39)
                drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls and the scoreboard check
    // ------------------------------------------------------------------
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= rcv_stall_pct);

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (n_errors < 40)
            $display("[%0t] result %0d %s: got %h, want %h", $realtime, n_results, what, got,
                     want);
        n_errors++;
    endtask

    always @(posedge clk)
    begin
        handle_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending, status", 32'(status), Z);
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.st)
                    report_mismatch("status", 32'(status), 32'(want.st));
                if (handle_out !== want.hout)
                    report_mismatch("handle_out", handle_out, want.hout);
                if (found_data !== want.fdata)
                    report_mismatch("found_data", found_data, want.fdata);
                if (found_size !== want.fsize)
                    report_mismatch("found_size", found_size, want.fsize);
                if (released_count !== want.cnt)
                    report_mismatch("released_count", 32'(released_count), 32'(want.cnt));
            end
        end
    end

    // Watchdog: any cycle where an item moves on either side restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("dedup_handle_table_unit regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial
    begin
        handle_req_t rq;
        int          slot;
        logic [31:0] fill_tag;

        for (int s = 0; s < TABLE_SLOTS; s++)
            mirror_used[s] = 1'b0;
        mirror_base = BASE_RESET;

        // Directed table. Base is at its reset value throughout; the table ends empty.
        dir_rows = '{
            // empty table: nothing to look up
            '{'{REQ_LOOKUP, 16'h0000, Z, Z, Z, 16'h0000, BR}, 1'b1,
              '{ST_INVALID, Z, Z, Z, 10'd0}},
            // all-zero key, then all-ones key, each new then reused
            '{'{REQ_ACQUIRE, 16'h0000, Z, Z, Z, 16'h0000, Z}, 1'b1,
              '{ST_NEW, BR, Z, Z, 10'd0}},
            '{'{REQ_ACQUIRE, 16'h0000, Z, Z, Z, 16'h0000, ONES}, 1'b1,
              '{ST_REUSED, BR, Z, Z, 10'd0}},
            '{'{REQ_ACQUIRE, 16'hFFFF, ONES, ONES, ONES, 16'hFFFF, Z}, 1'b1,
              '{ST_NEW, BR + 1, Z, Z, 10'd0}},
            '{'{REQ_ACQUIRE, 16'hFFFF, ONES, ONES, ONES, 16'hFFFF, ONES}, 1'b1,
              '{ST_REUSED, BR + 1, Z, Z, 10'd0}},
            '{'{REQ_LOOKUP, 16'h0000, Z, Z, Z, 16'h0000, BR + 1}, 1'b1,
              '{ST_LOOKUP_OK, Z, ONES, ONES, 10'd0}},
            '{'{REQ_LOOKUP, 16'hFFFF, ONES, ONES, ONES, 16'hFFFF, BR}, 1'b1,
              '{ST_LOOKUP_OK, Z, Z, Z, 10'd0}},
            // inside the window but unused, then window edges
            '{'{REQ_LOOKUP, 16'h0000, Z, Z, Z, 16'h0000, BR + 2}, 1'b1,
              '{ST_INVALID, Z, Z, Z, 10'd0}},
            '{'{REQ_LOOKUP, 16'h0000, Z, Z, Z, 16'h0000, BR + 32'(TABLE_SLOTS - 1)}, 1'b1,
              '{ST_INVALID, Z, Z, Z, 10'd0}},
            '{'{REQ_LOOKUP, 16'h0000, Z, Z, Z, 16'h0000, BR + 32'(TABLE_SLOTS)}, 1'b1,
              '{ST_INVALID, Z, Z, Z, 10'd0}},
            '{'{REQ_LOOKUP, 16'h0000, Z, Z, Z, 16'h0000, BR - 1}, 1'b1,
              '{ST_INVALID, Z, Z, Z, 10'd0}},
            '{'{REQ_LOOKUP, 16'h0000, Z, Z, Z, 16'h0000, Z}, 1'b1,
              '{ST_INVALID, Z, Z, Z, 10'd0}},
            '{'{REQ_LOOKUP, 16'h0000, Z, Z, Z, 16'h0000, ONES}, 1'b1,
              '{ST_INVALID, Z, Z, Z, 10'd0}},
            // unknown type carrying a handle that would hit: still invalid, all zero
            '{'{REQ_UNKNOWN, 16'hFFFF, ONES, ONES, ONES, 16'hFFFF, BR}, 1'b1,
              '{ST_INVALID, Z, Z, Z, 10'd0}},
            // keys differing only in language, only in owner
            '{'{REQ_ACQUIRE, 16'hFFFF, ONES, ONES, ONES, 16'hFFFE, Z}, 1'b1,
              '{ST_NEW, BR + 2, Z, Z, 10'd0}},
            '{'{REQ_ACQUIRE, 16'h0000, ONES, ONES, ONES, 16'hFFFF, Z}, 1'b1,
              '{ST_NEW, BR + 3, Z, Z, 10'd0}},
            // release of an owner with nothing, then of one with two slots
            '{'{REQ_RELEASE, 16'h1234, ONES, Z, ONES, 16'h0000, Z}, 1'b1,
              '{ST_RELEASED, Z, Z, Z, 10'd0}},
            '{'{REQ_RELEASE, 16'hFFFF, Z, ONES, Z, 16'hFFFF, ONES}, 1'b1,
              '{ST_RELEASED, Z, Z, Z, 10'd2}},
            // refills the lowest hole
            '{'{REQ_ACQUIRE, 16'h0007, 32'h5A5A_5A5A, 32'h1234_5678, 32'h0000_0100, 16'h0409, Z},
              1'b0, '{ST_INVALID, Z, Z, Z, 10'd0}},
            '{'{REQ_LOOKUP, 16'h0000, Z, Z, Z, 16'h0000, BR + 2}, 1'b1,
              '{ST_INVALID, Z, Z, Z, 10'd0}},
            '{'{REQ_LOOKUP, 16'h0000, Z, Z, Z, 16'h0000, BR + 3}, 1'b0,
              '{ST_INVALID, Z, Z, Z, 10'd0}},
            '{'{REQ_RELEASE, 16'h0000, Z, Z, Z, 16'h0000, Z}, 1'b1,
              '{ST_RELEASED, Z, Z, Z, 10'd2}},
            '{'{REQ_LOOKUP, 16'h0000, Z, Z, Z, 16'h0000, BR}, 1'b1,
              '{ST_INVALID, Z, Z, Z, 10'd0}},
            '{'{REQ_ACQUIRE, 16'h0007, 32'h5A5A_5A5A, 32'h1234_5678, 32'h0000_0100, 16'h0409, Z},
              1'b0, '{ST_INVALID, Z, Z, Z, 10'd0}},
            '{'{REQ_RELEASE, 16'h0007, ONES, ONES, ONES, 16'hFFFF, ONES}, 1'b1,
              '{ST_RELEASED, Z, Z, Z, 10'd1}}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, no idling on either side. The clearing sweep after reset
        // simply shows up as in_ready low on the first item.
        foreach (dir_rows[i])
            issue(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].res);

        // Random traffic, base still at reset value, no idling.
        run_mix(130, 1'b0);

        // Base zero, sender idles half the time.
        snd_idle_pct = 50;
        set_base(Z);
        run_mix(130, 1'b0);

        // Base all ones (slot one wraps to handle zero), receiver stalls half the
        // time, sender holds off periodically until everything is back.
        snd_idle_pct  = 0;
        rcv_stall_pct = 50;
        set_base(ONES);
        run_mix(130, 1'b1);

        // Fill phase: base chosen so the handle window wraps mid-table.
        snd_idle_pct  = 32;
        rcv_stall_pct = 32;
        set_base(32'hFFFF_FF00);

        // Empty the table owner by owner so a single owner can then take all slots.
        for (slot = find_slot(1'b1, 1'b0); slot >= 0; slot = find_slot(1'b1, 1'b0))
        begin
            rq      = fresh_key(mirror_owner[slot]);
            rq.kind = REQ_RELEASE;
            issue(rq, 1'b0, no_override);
        end

        // Fill every slot with distinct keys of one owner, with lookups in between.
        fill_tag = 32'hF111_0000;
        while (find_slot(1'b0, 1'b0) >= 0)
        begin
            rq = fresh_key(16'hFFFF);
            if ($urandom_range(3) == 0)
            begin
                rq.kind = REQ_LOOKUP;
                rq.hval = mirror_base + $urandom_range(TABLE_SLOTS - 1);
            end
            else
            begin
                rq.data_addr = fill_tag;
                fill_tag++;
                remember_key(rq);
            end
            issue(rq, 1'b0, no_override);
        end

        // Full table: new keys are refused, known keys are still reused.
        for (int k = 0; k < 4; k++)
        begin
            rq           = fresh_key(16'hFFFF);
            rq.data_addr = fill_tag;
            fill_tag++;
            issue(rq, 1'b0, no_override);
            issue(recent_keys[$urandom_range(recent_keys.size() - 1)], 1'b0, no_override);
        end

        // Window edges around the wrap point with every slot used.
        for (int k = 0; k < 5; k++)
        begin
            rq      = fresh_key(16'hFFFF);
            rq.kind = REQ_LOOKUP;
            case (k)
                0:       rq.hval = mirror_base + 32'(TABLE_SLOTS - 1);
                1:       rq.hval = mirror_base + 32'(TABLE_SLOTS);
                2:       rq.hval = mirror_base - 1;
                3:       rq.hval = Z;
                default: rq.hval = ONES;
            endcase
            issue(rq, 1'b0, no_override);
        end

        // One release frees the whole table: largest count.
        rq      = fresh_key(16'hFFFF);
        rq.kind = REQ_RELEASE;
        issue(rq, 1'b0, no_override);

        // Random base, both sides idling.
        set_base($urandom);
        run_mix(100, 1'b0);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (n_errors == 0)
            $display("dedup_handle_table_unit regression: pass");
        else
            $display("dedup_handle_table_unit regression: fail");
        $finish;
    end

endmodule
